// File: src/gpm_pkg.sv
package gpm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int POS_N       = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(POS_N);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int SCAN_LEVELS = LEN_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ANY_ONE = 8'h3F;
  localparam logic [7:0] CH_ANY_SEQ = 8'h2A;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_SUBJECT = 2'd1,
    REQ_FINISH  = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef struct packed {
    req_t       kind;
    logic [7:0] ch;
    logic       is_star;
    logic       is_any;
  } op_t;

endpackage

// File: src/gpm_front.sv
module gpm_front
  import gpm_pkg::*;
(
  input  logic       in_valid,
  input  logic [1:0] req_type,
  input  logic [7:0] char_value,
  input  logic       queue_full,
  output logic       in_stall,
  output logic       push,
  output op_t        push_op
);

  assign in_stall = queue_full;
  assign push     = in_valid & ~queue_full;

  always_comb begin
    push_op.kind    = req_t'(req_type);
    push_op.ch      = char_value;
    push_op.is_star = (char_value == CH_ANY_SEQ);
    push_op.is_any  = (char_value == CH_ANY_ONE);
  end

endmodule

// File: src/gpm_queue.sv
module gpm_queue
  import gpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// File: src/gpm_back.sv
module gpm_back
  import gpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  op_t  head_op,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic matched,
  output logic pattern_overflow
);

  logic [7:0]             store [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_bits;
  logic [PATTERN_MAX-1:0] any_bits;
  logic [PATTERN_MAX-1:0] len_mask;
  logic [LEN_W-1:0]       len;
  logic                   overflow;
  logic [POS_N-1:0]       raw;

  logic [PATTERN_MAX-1:0] star_valid;
  logic [PATTERN_MAX-1:0] hit;
  logic [POS_N-1:0]       pass;
  logic [POS_N-1:0]       closed;
  logic [POS_N-1:0]       stepped;
  logic                   room;
  logic                   out_free;

  // Prefix scan: position j reachable from active i through a run of stars.
  function automatic logic [POS_N-1:0] close_stars(input logic [POS_N-1:0] v,
                                                    input logic [POS_N-1:0] p);
    logic [POS_N-1:0] c;
    logic [POS_N-1:0] q;
    logic [POS_N-1:0] cn;
    logic [POS_N-1:0] qn;
    c = v;
    q = p;
    for (int k = 0; k < SCAN_LEVELS; k++) begin
      cn = c;
      qn = q;
      for (int j = 0; j < POS_N; j++) begin
        if (j >= (1 << k)) begin
          cn[j] = c[j] | (q[j] & c[j - (1 << k)]);
          qn[j] = q[j] & q[j - (1 << k)];
        end
      end
      c = cn;
      q = qn;
    end
    return c;
  endfunction

  assign star_valid = len_mask & star_bits;
  assign pass       = {star_valid, 1'b0};
  assign closed     = close_stars(raw, pass);
  assign room       = (len < LEN_W'(PATTERN_MAX));

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      hit[i] = closed[i] & len_mask[i] & ~star_bits[i]
             & (any_bits[i] | (store[i] == head_op.ch));
    end
    stepped = {hit, 1'b0} | {1'b0, closed[PATTERN_MAX-1:0] & star_valid};
  end

  assign out_free = ~out_valid | ~out_stall;
  assign pop      = head_valid & ((head_op.kind != REQ_FINISH) | out_free);

  always_ff @(posedge clk) begin
    if (pop && head_op.kind == REQ_APPEND && room) begin
      store[len[IDX_W-1:0]]     <= head_op.ch;
      star_bits[len[IDX_W-1:0]] <= head_op.is_star;
      any_bits[len[IDX_W-1:0]]  <= head_op.is_any;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.kind == REQ_FINISH) begin
      matched          <= closed[len];
      pattern_overflow <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_mask  <= '0;
      len       <= '0;
      overflow  <= 1'b0;
      raw       <= POS_N'(1);
      out_valid <= 1'b0;
    end else begin
      if (pop && head_op.kind == REQ_FINISH) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (head_op.kind)
          REQ_APPEND: begin
            if (room) begin
              len_mask[len[IDX_W-1:0]] <= 1'b1;
              len                      <= len + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            raw <= POS_N'(1);
          end
          REQ_SUBJECT: begin
            raw <= stepped;
          end
          REQ_FINISH: begin
            raw <= POS_N'(1);
          end
          REQ_CLEAR: begin
            len_mask <= '0;
            len      <= '0;
            overflow <= 1'b0;
            raw      <= POS_N'(1);
          end
          default: begin
            raw <= raw;
          end
        endcase
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_mask_len: assert property (@(posedge clk) disable iff (rst)
    $countones(len_mask) == int'(len))
    else $error("length mask disagrees with length");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    (pop && head_op.kind == REQ_FINISH) |=> out_valid)
    else $error("finish did not raise a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(pop && head_op.kind == REQ_FINISH))
    else $error("pending result overwritten");

endmodule

// File: src/glob_pattern_matcher.sv
// Glob matcher taking one transaction per clock while in_stall is low: '*'
// matches any run of bytes, '?' any single byte, other bytes themselves.
// Append (0) and clear (3) edit a pattern of up to PATTERN_MAX bytes and
// restart the subject; subject bytes (1) advance the set of live pattern
// positions; finish (2) returns matched and the sticky overflow flag and
// restarts the subject. Transactions pass a four-entry queue into the engine,
// which writes a finish result to the output register, where it holds until
// taken; only a stalled output register holds up further finishes. The star
// closure is a log-depth prefix scan, so the whole position vector is
// computed combinationally for each subject byte.
module glob_pattern_matcher
  import gpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] char_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       pattern_overflow
);

  logic queue_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic head_valid;
  op_t  head_op;

  gpm_front u_front (
    .in_valid   (in_valid),
    .req_type   (req_type),
    .char_value (char_value),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_op    (push_op)
  );

  gpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  gpm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_op          (head_op),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gpm_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1080;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [1:0] req_type   = 2'b00;
  logic [7:0] char_value = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic       matched;
  logic       pattern_overflow;

  glob_pattern_matcher dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .char_value       (char_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // glob state mirror
  logic [7:0]       pat_mem [PATTERN_MAX];
  int unsigned      pat_len;
  logic [POS_N-1:0] live_pos;
  logic             ovf_sticky;
  verdict_t         verdicts_due[$];

  int unsigned items_sent         = 0;
  int unsigned burst_left         = 1;
  int unsigned verdicts_checked   = 0;
  int unsigned matches_seen       = 0;
  int unsigned overflows_seen     = 0;
  int unsigned mismatches         = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned hold_asked         = 0;
  int unsigned hold_done          = 0;
  int unsigned hold_left          = 0;
  int unsigned rx_tick            = 0;
  longint unsigned cycle_no       = 0;

  function automatic logic [POS_N-1:0] close_stars(logic [POS_N-1:0] v);
    int i;
    for (i = 0; i < pat_len; i++)
      if (v[i] && pat_mem[i] == CH_ANY_SEQ) v[i+1] = 1'b1;
    return v;
  endfunction

  function automatic void restart_subject_pred();
    logic [POS_N-1:0] v;
    v    = '0;
    v[0] = 1'b1;
    live_pos = close_stars(v);
  endfunction

  function automatic void glob_predict(req_t k, logic [7:0] c);
    logic [POS_N-1:0] nxt;
    verdict_t         v;
    int               i;
    case (k)
      REQ_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_mem[pat_len] = c;
          pat_len++;
        end else begin
          ovf_sticky = 1'b1;
        end
        restart_subject_pred();
      end
      REQ_SUBJECT: begin
        nxt = '0;
        for (i = 0; i < pat_len; i++) begin
          if (live_pos[i]) begin
            if (pat_mem[i] == CH_ANY_SEQ) nxt[i] = 1'b1;
            else if (pat_mem[i] == CH_ANY_ONE || pat_mem[i] == c) nxt[i+1] = 1'b1;
          end
        end
        live_pos = close_stars(nxt);
      end
      REQ_FINISH: begin
        v.matched  = live_pos[pat_len];
        v.overflow = ovf_sticky;
        verdicts_due = {verdicts_due, v};
        restart_subject_pred();
      end
      REQ_CLEAR: begin
        pat_len    = 0;
        ovf_sticky = 1'b0;
        restart_subject_pred();
      end
    endcase
  endfunction

  // one transaction; sender runs in bursts with random gaps between them
  task automatic send_item(req_t k, logic [7:0] c);
    int unsigned gap;
    in_valid   <= 1'b1;
    req_type   <= k;
    char_value <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    glob_predict(k, c);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_text(req_t k, string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(k, s[i]);
  endtask

  function automatic byte unsigned pick_pattern_byte();
    case ($urandom_range(0, 11))
      0, 1, 2: return "a";
      3, 4:    return "b";
      5:       return "c";
      6, 7:    return CH_ANY_ONE;
      8, 9:    return CH_ANY_SEQ;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte unsigned pick_subject_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return "a";
      3, 4:    return "b";
      5, 6:    return "c";
      7:       return CH_ANY_ONE;
      8:       return CH_ANY_SEQ;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly a subject that follows the pattern, sometimes mutated or free-form
  function automatic void build_subject(ref byte unsigned pat[$], ref byte unsigned subj[$]);
    subj.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, 8)) subj = {subj, pick_subject_byte()};
    end else begin
      foreach (pat[i]) begin
        if (pat[i] == CH_ANY_SEQ)
          repeat ($urandom_range(0, 3)) subj = {subj, pick_subject_byte()};
        else if (pat[i] == CH_ANY_ONE)
          subj = {subj, pick_subject_byte()};
        else
          subj = {subj, pat[i]};
      end
      if (subj.size() != 0 && $urandom_range(0, 3) == 0)
        subj[$urandom_range(0, subj.size() - 1)] = pick_subject_byte();
      if ($urandom_range(0, 7) == 0) subj = {subj, pick_subject_byte()};
    end
  endfunction

  task automatic test_empty_pattern();
    send_item(REQ_FINISH, 8'hFF);
    send_item(REQ_SUBJECT, 8'h00);
    send_item(REQ_FINISH, 8'h00);
  endtask

  task automatic test_literal_extremes();
    send_item(REQ_APPEND, 8'h00);
    send_item(REQ_APPEND, 8'hFF);
    send_item(REQ_SUBJECT, 8'h00);
    send_item(REQ_SUBJECT, 8'hFF);
    send_item(REQ_FINISH, 8'h55);
    send_item(REQ_SUBJECT, 8'hFF);
    send_item(REQ_SUBJECT, 8'h00);
    send_item(REQ_FINISH, 8'hAA);
  endtask

  task automatic test_wildcards();
    send_item(REQ_CLEAR, 8'hFF);
    send_text(REQ_APPEND, "?*");
    send_text(REQ_SUBJECT, "x");
    send_item(REQ_FINISH, 8'h00);
    send_item(REQ_FINISH, 8'h00);
    send_text(REQ_SUBJECT, "abc");
    send_item(REQ_FINISH, 8'h00);
    // a pattern load mid-subject restarts the subject
    send_text(REQ_SUBJECT, "q");
    send_item(REQ_APPEND, "z");
    send_text(REQ_SUBJECT, "az");
    send_item(REQ_FINISH, 8'h00);
  endtask

  task automatic test_overflow();
    send_item(REQ_CLEAR, 8'h00);
    repeat (PATTERN_MAX) send_item(REQ_APPEND, CH_ANY_SEQ);
    send_item(REQ_SUBJECT, "k");
    send_item(REQ_APPEND, "k");
    send_item(REQ_SUBJECT, "k");
    send_item(REQ_FINISH, 8'h00);
    send_item(REQ_FINISH, 8'h00);
    send_item(REQ_CLEAR, 8'h00);
    send_item(REQ_FINISH, 8'h00);
  endtask

  task automatic test_output_backpressure();
    hold_asked++;
    send_item(REQ_APPEND, CH_ANY_SEQ);
    send_item(REQ_APPEND, "a");
    repeat (24) begin
      send_item(REQ_FINISH, 8'h00);
      send_item(REQ_SUBJECT, ($urandom_range(0, 1) == 0) ? 8'h61 : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_sequences();
    byte unsigned pat[$];
    byte unsigned subj[$];
    int unsigned  start;
    int unsigned  plen;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pat.delete();
      plen = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 7);
      repeat (plen) pat = {pat, pick_pattern_byte()};
      send_item(REQ_CLEAR, 8'($urandom_range(0, 255)));
      foreach (pat[i]) send_item(REQ_APPEND, pat[i]);
      repeat ($urandom_range(1, 4)) begin
        build_subject(pat, subj);
        foreach (subj[i]) begin
          if ($urandom_range(0, 19) == 0)
            send_item(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          send_item(REQ_SUBJECT, subj[i]);
        end
        send_item(REQ_FINISH, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver: rotating stall pattern, plus long holds on request
  always @(posedge clk) begin
    rx_tick++;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_done != hold_asked) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case ((rx_tick / 256) % 4)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && in_valid && in_stall) input_stall_cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("cycle %0d: unexpected transaction, matched=%0b overflow=%0b",
                   cycle_no, matched, pattern_overflow);
      end else begin
        want = verdicts_due.pop_front();
        verdicts_checked++;
        if (want.matched) matches_seen++;
        if (want.overflow) overflows_seen++;
        if (matched !== want.matched || pattern_overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("cycle %0d: expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                     cycle_no, want.matched, want.overflow, matched, pattern_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_no, verdicts_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    pat_len    = 0;
    ovf_sticky = 1'b0;
    restart_subject_pred();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_literal_extremes();
    test_wildcards();
    test_overflow();
    test_output_backpressure();
    test_random_sequences();

    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions: empty, literal, wildcard, overflow, back-pressure and random globs",
             items_sent);
    $display("%0d verdicts checked (%0d matched, %0d with overflow), %0d input stall cycles",
             verdicts_checked, matches_seen, overflows_seen, input_stall_cycles);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
src/gpm_pkg.sv
src/gpm_front.sv
src/gpm_queue.sv
src/gpm_back.sv
src/glob_pattern_matcher.sv
tb/tb_top.sv
